/* design/bnr_pkg.sv */
// Shared types and constants for the bounding-box normalise and remap core.
package bnr_pkg;

   localparam int MaxWidth   = 128;
   localparam int MaxHeight  = 128;
   localparam int CoordW     = $clog2(MaxWidth);
   localparam int RowW       = $clog2(MaxHeight);
   localparam int FrameDepth = MaxWidth * MaxHeight;
   localparam int IndexW     = $clog2(FrameDepth);
   localparam int SizeW      = 8;
   localparam int QueueDepth = 2;
   localparam int DivW       = 14;
   localparam logic [7:0] White = 8'd255;

   localparam logic CsrWidth  = 1'b0;
   localparam logic CsrHeight = 1'b1;

   localparam logic KindLoad  = 1'b0;
   localparam logic KindQuery = 1'b1;

   typedef struct packed {
      logic [CoordW-1:0] xmin;
      logic [CoordW-1:0] xmax;
      logic [RowW-1:0]   ymin;
      logic [RowW-1:0]   ymax;
      logic              ink;
   } box_type;

   // classified query handed from front to back
   typedef struct packed {
      logic              in_box;
      logic              sample_ink;
      logic [CoordW-1:0] offx;
      logic [CoordW-1:0] spanx_t;
      logic [CoordW-1:0] spanx_s;
      logic [CoordW-1:0] basex;
      logic [RowW-1:0]   offy;
      logic [RowW-1:0]   spany_t;
      logic [RowW-1:0]   spany_s;
      logic [RowW-1:0]   basey;
      logic [CoordW:0]   width;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_DIVX, BK_DIVY, BK_MUL, BK_READ, BK_EMIT
   } back_state_type;

endpackage

/* design/bnr_front.sv */
// Front: takes items, writes loads to the frame store, tracks ink boxes, classifies queries.
module bnr_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         realign,
   input  logic                         kind,
   input  logic                         frame_start,
   input  logic [7:0]                   template_red,
   input  logic [7:0]                   sample_grey,
   input  logic [bnr_pkg::CoordW-1:0]   query_x,
   input  logic [bnr_pkg::RowW-1:0]     query_y,
   input  logic [bnr_pkg::CoordW:0]     eff_w,
   input  logic [bnr_pkg::RowW:0]       eff_h,
   output logic                         aligning,
   output logic                         wr_en,
   output logic [bnr_pkg::IndexW-1:0]   wr_addr,
   output logic [7:0]                   wr_data,
   output logic                         job_valid,
   output bnr_pkg::job_type             job
);
   localparam int AlCntW = $clog2(bnr_pkg::IndexW + 1);
   logic [bnr_pkg::IndexW:0]   count_ff, count_in;
   logic [bnr_pkg::CoordW-1:0] x_ff, x_in;
   logic [bnr_pkg::RowW-1:0]   y_ff, y_in;
   bnr_pkg::box_type tbox_ff, tbox_in, sbox_ff, sbox_in, clr, tb, sb;
   logic [bnr_pkg::IndexW:0]   lc;
   logic [bnr_pkg::CoordW-1:0] lx;
   logic [bnr_pkg::RowW-1:0]   ly;
   logic [bnr_pkg::IndexW+1:0] area;
   logic                       take;
   logic                       al_ff, al_in;
   logic [AlCntW-1:0]          ac_ff, ac_in;
   logic [bnr_pkg::IndexW:0]   aq_ff, aq_in;
   logic [bnr_pkg::CoordW-1:0] ar_ff, ar_in;
   logic [bnr_pkg::CoordW:0]   al_trial;

   assign aligning = al_ff;

   always_comb begin
      clr.xmin = bnr_pkg::CoordW'(eff_w - 1'b1);
      clr.ymin = bnr_pkg::RowW'(eff_h - 1'b1);
      clr.xmax = '0;
      clr.ymax = '0;
      clr.ink  = 1'b0;
      area = (bnr_pkg::IndexW+2)'(eff_w) * (bnr_pkg::IndexW+2)'(eff_h);
      lc = frame_start ? '0 : count_ff;
      lx = frame_start ? '0 : x_ff;
      ly = frame_start ? '0 : y_ff;
      tb = frame_start ? clr : tbox_ff;
      sb = frame_start ? clr : sbox_ff;
      take = accept && (kind == bnr_pkg::KindLoad);
      count_in = count_ff; x_in = x_ff; y_in = y_ff;
      tbox_in = tbox_ff; sbox_in = sbox_ff;
      wr_en = 1'b0;
      if (take) begin
         tbox_in = tb; sbox_in = sb;
         count_in = lc; x_in = lx; y_in = ly;
         if ({1'b0, lc} < area) begin
            wr_en = 1'b1;
            if (template_red == 8'd0) begin
               if (lx < tb.xmin) tbox_in.xmin = lx;
               if (lx > tb.xmax) tbox_in.xmax = lx;
               if (ly < tb.ymin) tbox_in.ymin = ly;
               if (ly > tb.ymax) tbox_in.ymax = ly;
               tbox_in.ink = 1'b1;
            end
            if (sample_grey == 8'd0) begin
               if (lx < sb.xmin) sbox_in.xmin = lx;
               if (lx > sb.xmax) sbox_in.xmax = lx;
               if (ly < sb.ymin) sbox_in.ymin = ly;
               if (ly > sb.ymax) sbox_in.ymax = ly;
               sbox_in.ink = 1'b1;
            end
            count_in = lc + 1'b1;
            // column wraps against the current width
            if ({1'b0, lx} + 1'b1 >= eff_w) begin
               x_in = '0;
               y_in = ly + 1'b1;
            end else begin
               x_in = lx + 1'b1;
            end
         end
      end
      // after a width write, re-derive column and row from the count,
      // one quotient bit a cycle
      al_in = al_ff; ac_in = ac_ff; aq_in = aq_ff; ar_in = ar_ff;
      al_trial = {ar_ff, aq_ff[bnr_pkg::IndexW]};
      if (realign) begin
         al_in = 1'b1; ac_in = '0; aq_in = count_in; ar_in = '0;
      end else if (al_ff) begin
         if (al_trial >= eff_w) begin
            ar_in = bnr_pkg::CoordW'(al_trial - eff_w);
            aq_in = {aq_ff[bnr_pkg::IndexW-1:0], 1'b1};
         end else begin
            ar_in = bnr_pkg::CoordW'(al_trial);
            aq_in = {aq_ff[bnr_pkg::IndexW-1:0], 1'b0};
         end
         ac_in = ac_ff + 1'b1;
         if (ac_ff == AlCntW'(bnr_pkg::IndexW)) begin
            al_in = 1'b0;
            x_in = ar_in;
            y_in = bnr_pkg::RowW'(aq_in);
         end
      end
      wr_addr = bnr_pkg::IndexW'(lc);
      wr_data = sample_grey;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; x_ff <= '0; y_ff <= '0;
         al_ff <= 1'b0;
         tbox_ff <= '{xmin: bnr_pkg::CoordW'(bnr_pkg::MaxWidth-1), xmax: '0,
                      ymin: bnr_pkg::RowW'(bnr_pkg::MaxHeight-1), ymax: '0, ink: 1'b0};
         sbox_ff <= '{xmin: bnr_pkg::CoordW'(bnr_pkg::MaxWidth-1), xmax: '0,
                      ymin: bnr_pkg::RowW'(bnr_pkg::MaxHeight-1), ymax: '0, ink: 1'b0};
      end else begin
         count_ff <= count_in; x_ff <= x_in; y_ff <= y_in;
         al_ff <= al_in;
         tbox_ff <= tbox_in; sbox_ff <= sbox_in;
      end
   end

   always_ff @(posedge clock) begin
      ac_ff <= ac_in; aq_ff <= aq_in; ar_ff <= ar_in;
   end

   always_comb begin
      job_valid = accept && (kind == bnr_pkg::KindQuery);
      job.in_box = tbox_ff.ink && query_x >= tbox_ff.xmin && query_x <= tbox_ff.xmax
                   && query_y >= tbox_ff.ymin && query_y <= tbox_ff.ymax;
      job.sample_ink = sbox_ff.ink;
      job.offx    = query_x - tbox_ff.xmin;
      job.spanx_t = tbox_ff.xmax - tbox_ff.xmin;
      job.spanx_s = sbox_ff.xmax - sbox_ff.xmin;
      job.basex   = sbox_ff.xmin;
      job.offy    = query_y - tbox_ff.ymin;
      job.spany_t = tbox_ff.ymax - tbox_ff.ymin;
      job.spany_s = sbox_ff.ymax - sbox_ff.ymin;
      job.basey   = sbox_ff.ymin;
      job.width   = eff_w;
   end
endmodule

/* design/bnr_queue.sv */
// Short queue of classified queries between front and back.
module bnr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bnr_pkg::job_type push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic             full,
   output bnr_pkg::job_type head
);
   localparam int PtrW = $clog2(bnr_pkg::QueueDepth);
   bnr_pkg::job_type slot_ff [bnr_pkg::QueueDepth];
   logic [PtrW-1:0] wp_ff, rp_ff;
   logic [PtrW:0]   fill_ff;

   assign not_empty = fill_ff != '0;
   assign full      = fill_ff == (PtrW+1)'(bnr_pkg::QueueDepth);
   assign head      = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_data;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; fill_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         fill_ff <= fill_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
      end
   end
endmodule

/* design/bnr_back.sv */
// Back: scales a query into the sample box with a shared serial divider and reads the store.
module bnr_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_ready,
   input  bnr_pkg::job_type            job,
   output logic                        job_pop,
   output logic                        idle,
   input  logic                        wr_en,
   input  logic [bnr_pkg::IndexW-1:0]  wr_addr,
   input  logic [7:0]                  wr_data,
   output logic                        rsp_valid,
   output logic [7:0]                  rsp_grey,
   output logic                        rsp_inside_box,
   output logic [bnr_pkg::IndexW-1:0]  rsp_source_index
);
   localparam int CntW = $clog2(bnr_pkg::DivW + 1);
   logic [7:0] frame_mem [bnr_pkg::FrameDepth];
   logic [7:0] rd_ff;

   bnr_pkg::back_state_type state_ff, state_in;
   bnr_pkg::job_type job_ff, job_in;
   logic [bnr_pkg::DivW-1:0]   quo_ff, quo_in, num;
   logic [bnr_pkg::DivW:0]     rem_ff, rem_in, trial;
   logic [CntW-1:0]            cnt_ff, cnt_in;
   logic [bnr_pkg::CoordW-1:0] sx_ff, sx_in, den;
   logic [bnr_pkg::RowW-1:0]   sy_ff, sy_in;
   logic [bnr_pkg::IndexW-1:0] idx_ff, idx_in;
   logic [bnr_pkg::IndexW+1:0] prod;
   logic                       in_ff, in_in, rd_ok_ff, rd_ok_in;

   assign idle = state_ff == bnr_pkg::BK_IDLE;

   always_comb begin
      state_in = state_ff; job_in = job_ff; quo_in = quo_ff; rem_in = rem_ff;
      cnt_in = cnt_ff; sx_in = sx_ff; sy_in = sy_ff; idx_in = idx_ff;
      in_in = in_ff; rd_ok_in = rd_ok_ff; job_pop = 1'b0;
      den = (state_ff == bnr_pkg::BK_DIVX) ? job_ff.spanx_t
                                           : bnr_pkg::CoordW'(job_ff.spany_t);
      trial = {rem_ff[bnr_pkg::DivW-1:0], quo_ff[bnr_pkg::DivW-1]};
      prod = (bnr_pkg::IndexW+2)'({1'b0, sy_ff}) * (bnr_pkg::IndexW+2)'(job_ff.width)
             + (bnr_pkg::IndexW+2)'(sx_ff);
      num = '0;
      case (state_ff)
         bnr_pkg::BK_IDLE: begin
            if (job_ready) begin
               job_pop = 1'b1;
               job_in = job;
               in_in = job.in_box;
               rd_ok_in = 1'b0;
               idx_in = '0;
               if (job.in_box && job.sample_ink) begin
                  num = bnr_pkg::DivW'(job.offx) * bnr_pkg::DivW'(job.spanx_s);
                  quo_in = num; rem_in = '0; cnt_in = '0;
                  state_in = bnr_pkg::BK_DIVX;
               end else begin
                  state_in = bnr_pkg::BK_EMIT;
               end
            end
         end
         bnr_pkg::BK_DIVX, bnr_pkg::BK_DIVY: begin
            // restoring division, one quotient bit a cycle
            if (trial >= {{(bnr_pkg::DivW+1-bnr_pkg::CoordW){1'b0}}, den}) begin
               rem_in = trial - (bnr_pkg::DivW+1)'(den);
               quo_in = {quo_ff[bnr_pkg::DivW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[bnr_pkg::DivW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(bnr_pkg::DivW - 1)) begin
               cnt_in = '0;
               if (state_ff == bnr_pkg::BK_DIVX) begin
                  sx_in = (den == '0) ? job_ff.basex
                          : job_ff.basex + bnr_pkg::CoordW'(quo_in);
                  num = bnr_pkg::DivW'(job_ff.offy) * bnr_pkg::DivW'(job_ff.spany_s);
                  quo_in = num; rem_in = '0;
                  state_in = bnr_pkg::BK_DIVY;
               end else begin
                  sy_in = (den == '0) ? job_ff.basey
                          : job_ff.basey + bnr_pkg::RowW'(quo_in);
                  state_in = bnr_pkg::BK_MUL;
               end
            end
         end
         bnr_pkg::BK_MUL: begin
            idx_in = bnr_pkg::IndexW'(prod);
            rd_ok_in = prod < (bnr_pkg::IndexW+2)'(bnr_pkg::FrameDepth);
            state_in = bnr_pkg::BK_READ;
         end
         bnr_pkg::BK_READ: state_in = bnr_pkg::BK_EMIT;
         bnr_pkg::BK_EMIT: state_in = bnr_pkg::BK_IDLE;
         default: state_in = bnr_pkg::BK_IDLE;
      endcase
      rsp_valid = state_ff == bnr_pkg::BK_EMIT;
      rsp_inside_box = in_ff;
      rsp_source_index = idx_ff;
      rsp_grey = (in_ff && job_ff.sample_ink) ? (rd_ok_ff ? rd_ff : 8'd0)
                                              : bnr_pkg::White;
   end

   always_ff @(posedge clock) begin
      if (wr_en) frame_mem[wr_addr] <= wr_data;
      rd_ff <= frame_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bnr_pkg::BK_IDLE;
      else state_ff <= state_in;
      job_ff <= job_in; quo_ff <= quo_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
      sx_ff <= sx_in; sy_ff <= sy_in; idx_ff <= idx_in;
      in_ff <= in_in; rd_ok_ff <= rd_ok_in;
   end
endmodule

/* design/bbox_normalize_remap_core.sv */
// Top level of the bounding-box normalise and remap core.
// Loads return nothing; they write the sample byte to a 16384-byte frame
// store and grow the template and sample ink boxes. A query returns one
// result. One that lies outside the template box, or comes when the sample
// has no ink, goes straight to the result; any other passes through the
// shared serial divider, which runs 14 steps for each axis, then an index
// multiply and a registered store read. The back finishes each query before
// it draws the next from the queue. Queries wait in a two-entry queue. busy
// is high while that queue is full; while a query is queued or being worked
// on and the item offered is a load, so a load never overwrites a store byte
// before an earlier query has read it; and after a width write, while the
// load position is re-derived from the load count against the new width
// (csr_ready is low then too). Results appear for one cycle on rsp_valid
// and cannot be held off.
module bbox_normalize_remap_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_kind,
   input  logic                         req_frame_start,
   input  logic [7:0]                   req_template_red,
   input  logic [7:0]                   req_sample_grey,
   input  logic [bnr_pkg::CoordW-1:0]   req_query_x,
   input  logic [bnr_pkg::RowW-1:0]     req_query_y,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_grey,
   output logic                         rsp_inside_box,
   output logic [bnr_pkg::IndexW-1:0]   rsp_source_index,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [bnr_pkg::SizeW-1:0]    csr_wdata
);
   logic [bnr_pkg::SizeW-1:0] width_ff, height_ff;
   logic [bnr_pkg::CoordW:0]  eff_w;
   logic [bnr_pkg::RowW:0]    eff_h;
   logic accept, wr_en, job_valid, q_ready, q_full, pop;
   logic back_idle, aligning, realign, csr_take;
   logic [bnr_pkg::IndexW-1:0] wr_addr;
   logic [7:0] wr_data;
   bnr_pkg::job_type job, head;

   // hold the size registers while the load position is re-derived
   assign csr_ready = !aligning;
   assign csr_take  = csr_valid && csr_ready;
   assign realign   = csr_take && (csr_index == bnr_pkg::CsrWidth);
   // hold loads back until every earlier query has read the store
   assign busy   = q_full || aligning ||
                   ((req_kind == bnr_pkg::KindLoad) && (q_ready || !back_idle));
   assign accept = start && !busy;

   // clamp the size registers to 1..max
   always_comb begin
      if (width_ff == '0) eff_w = (bnr_pkg::CoordW+1)'(1);
      else if (width_ff > bnr_pkg::SizeW'(bnr_pkg::MaxWidth))
         eff_w = (bnr_pkg::CoordW+1)'(bnr_pkg::MaxWidth);
      else eff_w = (bnr_pkg::CoordW+1)'(width_ff);
      if (height_ff == '0) eff_h = (bnr_pkg::RowW+1)'(1);
      else if (height_ff > bnr_pkg::SizeW'(bnr_pkg::MaxHeight))
         eff_h = (bnr_pkg::RowW+1)'(bnr_pkg::MaxHeight);
      else eff_h = (bnr_pkg::RowW+1)'(height_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bnr_pkg::SizeW'(bnr_pkg::MaxWidth);
         height_ff <= bnr_pkg::SizeW'(bnr_pkg::MaxHeight);
      end else if (csr_take) begin
         if (csr_index == bnr_pkg::CsrWidth) width_ff <= csr_wdata;
         else height_ff <= csr_wdata;
      end
   end

   bnr_front u_front (
      .clock, .reset, .accept, .realign,
      .kind(req_kind), .frame_start(req_frame_start),
      .template_red(req_template_red), .sample_grey(req_sample_grey),
      .query_x(req_query_x), .query_y(req_query_y),
      .eff_w, .eff_h, .aligning, .wr_en, .wr_addr, .wr_data, .job_valid, .job
   );

   bnr_queue u_queue (
      .clock, .reset, .push(job_valid), .push_data(job), .pop,
      .not_empty(q_ready), .full(q_full), .head
   );

   bnr_back u_back (
      .clock, .reset, .job_ready(q_ready), .job(head), .job_pop(pop),
      .idle(back_idle),
      .wr_en, .wr_addr, .wr_data,
      .rsp_valid, .rsp_grey, .rsp_inside_box, .rsp_source_index
   );
endmodule
